// ===== hw/rtl/spit_pkg.sv =====
package spit_pkg;

	// Coordinate width of every endpoint field
	localparam int COORD_WIDTH = 16;
	// Difference of two coordinates
	localparam int DIFF_W = COORD_WIDTH + 1;
	// Product of two differences
	localparam int PROD_W = 2 * DIFF_W;
	// Difference of two products
	localparam int SUM_W = PROD_W + 1;
	// Input beat: eight coordinates, padded to whole bytes
	localparam int IN_W = ((8 * COORD_WIDTH + 7) / 8) * 8;
	localparam int VERDICT_W = 2;
	localparam int OUT_W = 8;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_DISJOINT = 2'd0,
		VERDICT_POINT    = 2'd1,
		VERDICT_OVERLAP  = 2'd2
	} verdict_t;

	// Lexicographic order: x first, then y
	function automatic logic pt_less(point_t p, point_t q);
		return (p.x != q.x) ? (p.x < q.x) : (p.y < q.y);
	endfunction

	// Difference of two coordinates, sign extended by one bit
	function automatic diff_t coord_diff(coord_t p, coord_t q);
		return diff_t'(p) - diff_t'(q);
	endfunction

	// Closed range test of v between two bounds given in either order
	function automatic logic in_span(coord_t v, coord_t s, coord_t e);
		return ((s <= v) && (v <= e)) || ((e <= v) && (v <= s));
	endfunction

endpackage

// ===== hw/rtl/segment_pair_intersect_test_unit.sv =====
// Segment pair intersection test.
//
// Input stream (s_axis_*): one beat carries two segments, eight signed
// coordinates of COORD_WIDTH bits. Output stream (m_axis_*): one beat per
// input beat, in order, carrying the verdict: disjoint, meet in one point,
// or collinear overlap along a stretch.
//
// Configuration: cfg_we/cfg_wdata write the touch_counts bit. When it is 1
// an endpoint or boundary contact counts as meeting; when 0 only strict
// crossings and strict overlaps count. Write it only while the unit is idle.
//
// Throughput is one pair per cycle while m_axis_tready stays high. Each
// input beat passes through the four register stages: differences and
// endpoint ordering, six 17x17 products, three cross-product sums, then the
// range checks into the output register.
//
// Reset clears every stage valid and sets touch_counts to 1. When the
// receiver holds m_axis_tready low the output beat waits in the last stage;
// empty stages in front of it still fill, so input is taken until all four
// stages hold a result.
module segment_pair_intersect_test_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration
	input  logic                    cfg_we,
	input  logic                    cfg_wdata,       // touch_counts
	// Segment pairs in
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
	// seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y
	input  logic [spit_pkg::IN_W-1:0] s_axis_tdata,
	// Verdicts out
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [spit_pkg::OUT_W-1:0] m_axis_tdata   // verdict, zero padded
);

	import spit_pkg::*;

	// Configuration register
	logic touch_counts_q;

	// Unpacked endpoints
	point_t pa, pb, pc, pd;

	// Stage handshake
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	// Stage 1: differences, degenerate flags, bounding boxes, endpoint order
	diff_t abx_s1, aby_s1, acx_s1, acy_s1, cdx_s1, cdy_s1;
	logic deg1_s1, deg2_s1, box_a_s1, box_c_s1;
	point_t min_ab_s1, max_ab_s1, min_cd_s1, max_cd_s1;

	// Stage 2: products, overlap bounds
	prod_t p_abx_cdy_s2, p_aby_cdx_s2, p_acx_aby_s2;
	prod_t p_acy_abx_s2, p_acx_cdy_s2, p_acy_cdx_s2;
	logic deg1_s2, deg2_s2, box_a_s2, box_c_s2;
	point_t lo_s2, hi_s2;

	// Stage 3: cross products, overlap order
	sum_t den_s3, unum_s3, tnum_s3;
	logic deg1_s3, deg2_s3, box_a_s3, box_c_s3;
	logic lo_lt_hi_s3, lo_eq_hi_s3;

	// Stage 4: verdict (output register)
	verdict_t verdict_s4;
	verdict_t verdict_d;

	// Numerator over denominator in [0,1] (touch) or (0,1) (strict)
	function automatic logic in_unit(sum_t num, sum_t den, logic touch);
		logic r;
		if (den > 0) begin
			r = touch ? ((num >= 0) && (num <= den)) : ((num > 0) && (num < den));
		end else begin
			r = touch ? ((num <= 0) && (den <= num)) : ((num < 0) && (den < num));
		end
		return r;
	endfunction

	assign pa.x = coord_t'(s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
	assign pa.y = coord_t'(s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
	assign pb.x = coord_t'(s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
	assign pb.y = coord_t'(s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH]);
	assign pc.x = coord_t'(s_axis_tdata[4*COORD_WIDTH +: COORD_WIDTH]);
	assign pc.y = coord_t'(s_axis_tdata[5*COORD_WIDTH +: COORD_WIDTH]);
	assign pd.x = coord_t'(s_axis_tdata[6*COORD_WIDTH +: COORD_WIDTH]);
	assign pd.y = coord_t'(s_axis_tdata[7*COORD_WIDTH +: COORD_WIDTH]);

	// A stage takes a new beat when it is empty or its beat moves on
	assign rdy_s4 = !v_s4 || m_axis_tready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {{(OUT_W - VERDICT_W){1'b0}}, verdict_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_counts_q <= 1'b1;
		end else if (cfg_we) begin
			touch_counts_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: subtract endpoints and order each segment's ends
	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			abx_s1    <= coord_diff(pb.x, pa.x);
			aby_s1    <= coord_diff(pb.y, pa.y);
			acx_s1    <= coord_diff(pc.x, pa.x);
			acy_s1    <= coord_diff(pc.y, pa.y);
			cdx_s1    <= coord_diff(pd.x, pc.x);
			cdy_s1    <= coord_diff(pd.y, pc.y);
			deg1_s1   <= (pa == pb);
			deg2_s1   <= (pc == pd);
			// point a inside the box of segment two, point c inside that of one
			box_a_s1  <= in_span(pa.x, pc.x, pd.x) && in_span(pa.y, pc.y, pd.y);
			box_c_s1  <= in_span(pc.x, pa.x, pb.x) && in_span(pc.y, pa.y, pb.y);
			min_ab_s1 <= pt_less(pb, pa) ? pb : pa;
			max_ab_s1 <= pt_less(pa, pb) ? pb : pa;
			min_cd_s1 <= pt_less(pd, pc) ? pd : pc;
			max_cd_s1 <= pt_less(pc, pd) ? pd : pc;
		end
	end

	// Stage 2: six products; overlap runs from the larger low end to the smaller high end
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			p_abx_cdy_s2 <= abx_s1 * cdy_s1;
			p_aby_cdx_s2 <= aby_s1 * cdx_s1;
			p_acx_aby_s2 <= acx_s1 * aby_s1;
			p_acy_abx_s2 <= acy_s1 * abx_s1;
			p_acx_cdy_s2 <= acx_s1 * cdy_s1;
			p_acy_cdx_s2 <= acy_s1 * cdx_s1;
			deg1_s2      <= deg1_s1;
			deg2_s2      <= deg2_s1;
			box_a_s2     <= box_a_s1;
			box_c_s2     <= box_c_s1;
			lo_s2        <= pt_less(min_ab_s1, min_cd_s1) ? min_cd_s1 : min_ab_s1;
			hi_s2        <= pt_less(max_cd_s1, max_ab_s1) ? max_cd_s1 : max_ab_s1;
		end
	end

	// Stage 3: cross products. tnum == 0 puts a on line cd, unum == 0 puts c on line ab
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			den_s3      <= sum_t'(p_abx_cdy_s2) - sum_t'(p_aby_cdx_s2);
			unum_s3     <= sum_t'(p_acx_aby_s2) - sum_t'(p_acy_abx_s2);
			tnum_s3     <= sum_t'(p_acx_cdy_s2) - sum_t'(p_acy_cdx_s2);
			deg1_s3     <= deg1_s2;
			deg2_s3     <= deg2_s2;
			box_a_s3    <= box_a_s2;
			box_c_s3    <= box_c_s2;
			lo_lt_hi_s3 <= pt_less(lo_s2, hi_s2);
			lo_eq_hi_s3 <= (lo_s2 == hi_s2);
		end
	end

	// Stage 4: classify
	always_comb begin
		verdict_d = VERDICT_DISJOINT;
		if (deg1_s3) begin
			// first segment is a point: test it on the second
			if (touch_counts_q && (tnum_s3 == 0) && box_a_s3) verdict_d = VERDICT_POINT;
		end else if (deg2_s3) begin
			if (touch_counts_q && (unum_s3 == 0) && box_c_s3) verdict_d = VERDICT_POINT;
		end else if ((den_s3 == 0) && (unum_s3 == 0)) begin
			// collinear: compare the overlap bounds
			if (touch_counts_q ? (lo_lt_hi_s3 || lo_eq_hi_s3) : lo_lt_hi_s3) begin
				verdict_d = lo_eq_hi_s3 ? VERDICT_POINT : VERDICT_OVERLAP;
			end
		end else if (den_s3 != 0) begin
			if (in_unit(tnum_s3, den_s3, touch_counts_q) &&
			    in_unit(unum_s3, den_s3, touch_counts_q)) begin
				verdict_d = VERDICT_POINT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			verdict_s4 <= verdict_d;
		end
	end

	// Four full stages and a stalled receiver block the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while pipeline full and stalled");

	// A bubble moving into the last stage leaves no output beat
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy_s4 && !v_s3) |=> !v_s4)
		else $error("output beat appeared from an empty stage");

	// Parallel, non-collinear segments never meet
	a_parallel: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy_s4 && !deg1_s3 && !deg2_s3 && (den_s3 == 0) && (unum_s3 != 0))
		|=> (verdict_s4 == VERDICT_DISJOINT))
		else $error("parallel segments reported as meeting");

	// A point as first segment without touch never meets
	a_point_strict: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy_s4 && deg1_s3 && !touch_counts_q)
		|=> (verdict_s4 == VERDICT_DISJOINT))
		else $error("point segment met with touch disabled");

endmodule

// ===== dv/segment_intersect_checker.sv =====
`timescale 1ns / 100ps

module segment_intersect_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [spit_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [spit_pkg::OUT_W-1:0] m_axis_tdata,
	output int                         mismatches,
	output int                         outstanding
);

	import spit_pkg::*;

	typedef struct packed {
		longint x;
		longint y;
	} vertex_t;

	logic     touch_counts_q;
	verdict_t pending_verdicts [$];
	verdict_t oldest;
	int       error_count;

	// Lexicographic order, x first
	function automatic logic precedes(vertex_t p, vertex_t q);
		return (p.x != q.x) ? (p.x < q.x) : (p.y < q.y);
	endfunction

	// Point on the closed segment s..e
	function automatic logic on_segment(vertex_t p, vertex_t s, vertex_t e);
		return ((p.x - s.x) * (e.y - s.y) == (p.y - s.y) * (e.x - s.x)) &&
			((s.x < e.x ? s.x : e.x) <= p.x) && (p.x <= (s.x < e.x ? e.x : s.x)) &&
			((s.y < e.y ? s.y : e.y) <= p.y) && (p.y <= (s.y < e.y ? e.y : s.y));
	endfunction

	// num/den within [0,1] when touching counts, else within (0,1)
	function automatic logic within_unit(longint num, longint den, logic touch);
		if (den > 0)
			return touch ? (0 <= num && num <= den) : (0 < num && num < den);
		return touch ? (num <= 0 && den <= num) : (num < 0 && den < num);
	endfunction

	function automatic verdict_t judge_pair(logic [IN_W-1:0] beat, logic touch);
		vertex_t a, b, c, d, lo, hi;
		longint abx, aby, acx, acy, cdx, cdy, den, unum, tnum;
		logic hit;
		a.x = longint'(coord_t'(beat[0*COORD_WIDTH +: COORD_WIDTH]));
		a.y = longint'(coord_t'(beat[1*COORD_WIDTH +: COORD_WIDTH]));
		b.x = longint'(coord_t'(beat[2*COORD_WIDTH +: COORD_WIDTH]));
		b.y = longint'(coord_t'(beat[3*COORD_WIDTH +: COORD_WIDTH]));
		c.x = longint'(coord_t'(beat[4*COORD_WIDTH +: COORD_WIDTH]));
		c.y = longint'(coord_t'(beat[5*COORD_WIDTH +: COORD_WIDTH]));
		d.x = longint'(coord_t'(beat[6*COORD_WIDTH +: COORD_WIDTH]));
		d.y = longint'(coord_t'(beat[7*COORD_WIDTH +: COORD_WIDTH]));
		abx = b.x - a.x;
		aby = b.y - a.y;
		acx = c.x - a.x;
		acy = c.y - a.y;
		cdx = d.x - c.x;
		cdy = d.y - c.y;

		// a zero-length segment only ever touches
		if (abx == 0 && aby == 0)
			return (touch && on_segment(a, c, d)) ? VERDICT_POINT : VERDICT_DISJOINT;
		if (cdx == 0 && cdy == 0)
			return (touch && on_segment(c, a, b)) ? VERDICT_POINT : VERDICT_DISJOINT;

		den  = abx * cdy - aby * cdx;
		unum = acx * aby - acy * abx;

		if (den == 0 && unum == 0) begin
			// shared stretch: larger of the lower ends to smaller of the upper ends
			lo = precedes(b, a) ? b : a;
			hi = precedes(d, c) ? d : c;
			lo = precedes(lo, hi) ? hi : lo;
			hi = precedes(a, b) ? b : a;
			c  = precedes(c, d) ? d : c;
			hi = precedes(c, hi) ? c : hi;
			hit = touch ? !precedes(hi, lo) : precedes(lo, hi);
			if (!hit)
				return VERDICT_DISJOINT;
			return (lo == hi) ? VERDICT_POINT : VERDICT_OVERLAP;
		end
		if (den == 0)
			return VERDICT_DISJOINT;

		tnum = acx * cdy - acy * cdx;
		return (within_unit(tnum, den, touch) && within_unit(unum, den, touch)) ?
			VERDICT_POINT : VERDICT_DISJOINT;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_counts_q <= 1'b1;
			pending_verdicts.delete();
			error_count = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				touch_counts_q <= cfg_wdata;

			// check the output first: a verdict cannot stem from a pair taken at this edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_verdicts.size() == 0) begin
					if (error_count < 10)
						$display("%0t: verdict beat %0d with none expected", $time,
							m_axis_tdata);
					error_count++;
				end else begin
					oldest = pending_verdicts.pop_front();
					if (m_axis_tdata[VERDICT_W-1:0] !== oldest ||
						m_axis_tdata[OUT_W-1:VERDICT_W] !== '0) begin
						if (error_count < 10)
							$display("%0t: verdict expected %0d, got %0d (padding %b)",
								$time, oldest, m_axis_tdata[VERDICT_W-1:0],
								m_axis_tdata[OUT_W-1:VERDICT_W]);
						error_count++;
					end
				end
			end

			// append the predicted verdict at the tail
			if (s_axis_tvalid && s_axis_tready)
				pending_verdicts = {pending_verdicts,
					judge_pair(s_axis_tdata, touch_counts_q)};

			mismatches  <= error_count;
			outstanding <= pending_verdicts.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	import spit_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_wdata;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;

	int   mismatches;
	int   outstanding;

	// sender gaps on/off, only touched by the stimulus process
	logic tx_gaps;
	// receiver stalls on/off and the one long hold-off, both set from stimulus
	logic rx_stalls;
	logic hold_phase;
	logic hold_done;
	int   hold_count;

	segment_pair_intersect_test_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	segment_intersect_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop: far beyond the slowest correct run of some seven hundred pairs
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	// Receiver: random back-pressure, plus one long hold-off counted here so
	// that the four stages fill and the input side stalls.
	initial begin
		m_axis_tready <= 1'b0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_phase && !hold_done) begin
				m_axis_tready <= 1'b0;
				for (hold_count = 0; hold_count < 80; hold_count++)
					@(posedge clk);
				hold_done = 1'b1;
			end else if (rx_stalls) begin
				m_axis_tready <= ($urandom_range(99) >= 24);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Pack eight coordinates, seg1 start x in the lowest bits
	function automatic logic [IN_W-1:0] pack_seg(int ax, int ay, int bx, int by,
		int cx, int cy, int dx, int dy);
		logic [IN_W-1:0] beat;
		beat = '0;
		beat[0*COORD_WIDTH +: COORD_WIDTH] = ax[COORD_WIDTH-1:0];
		beat[1*COORD_WIDTH +: COORD_WIDTH] = ay[COORD_WIDTH-1:0];
		beat[2*COORD_WIDTH +: COORD_WIDTH] = bx[COORD_WIDTH-1:0];
		beat[3*COORD_WIDTH +: COORD_WIDTH] = by[COORD_WIDTH-1:0];
		beat[4*COORD_WIDTH +: COORD_WIDTH] = cx[COORD_WIDTH-1:0];
		beat[5*COORD_WIDTH +: COORD_WIDTH] = cy[COORD_WIDTH-1:0];
		beat[6*COORD_WIDTH +: COORD_WIDTH] = dx[COORD_WIDTH-1:0];
		beat[7*COORD_WIDTH +: COORD_WIDTH] = dy[COORD_WIDTH-1:0];
		return beat;
	endfunction

	// Mostly small grids and built-up collinear or touching pairs, where the
	// interesting verdicts live; the rest is extremes and raw noise.
	function automatic logic [IN_W-1:0] random_pair();
		int c [8];
		int corners [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
		int sel, px, py, dx, dy, k;
		sel = $urandom_range(99);
		if (sel < 45) begin
			for (k = 0; k < 8; k++)
				c[k] = int'($urandom_range(16)) - 8;
		end else if (sel < 60) begin
			// four points on one line through p along (dx, dy)
			px = int'($urandom_range(200)) - 100;
			py = int'($urandom_range(200)) - 100;
			dx = int'($urandom_range(6)) - 3;
			dy = int'($urandom_range(6)) - 3;
			for (k = 0; k < 4; k++) begin
				sel = int'($urandom_range(12)) - 6;
				c[2*k]   = px + sel * dx;
				c[2*k+1] = py + sel * dy;
			end
		end else if (sel < 75) begin
			for (k = 0; k < 8; k++)
				c[k] = int'($urandom_range(20)) - 10;
			// collapse a segment or share an endpoint
			case ($urandom_range(3))
				0: begin
					c[2] = c[0];
					c[3] = c[1];
				end
				1: begin
					c[6] = c[4];
					c[7] = c[5];
				end
				2: begin
					c[4] = c[2];
					c[5] = c[3];
				end
				default: begin
					c[6] = c[0];
					c[7] = c[1];
				end
			endcase
		end else if (sel < 85) begin
			for (k = 0; k < 8; k++)
				c[k] = corners[$urandom_range(6)];
		end else begin
			for (k = 0; k < 8; k++)
				c[k] = int'($urandom_range(65535));
		end
		return pack_seg(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endfunction

	// Offer one beat and hold it until taken; gaps go in first when enabled
	task automatic offer_pair(input logic [IN_W-1:0] beat);
		if (tx_gaps) begin
			while ($urandom_range(99) < 24) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= beat;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop valid and wait until every verdict has come back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_touch(input logic value);
		settle();
		// allow the pipeline depth to empty past the last verdict
		repeat (6) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_run(input int count);
		repeat (count)
			offer_pair(random_pair());
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		rx_stalls     <= 1'b1;
		hold_phase    <= 1'b0;
		tx_gaps        = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs with touching counted (the reset value)
		// both segments the same single point
		offer_pair(pack_seg(0, 0, 0, 0, 0, 0, 0, 0));
		// seg1 a point inside seg2, at its end, and off it
		offer_pair(pack_seg(0, 0, 0, 0, -5, -5, 5, 5));
		offer_pair(pack_seg(5, 5, 5, 5, -5, -5, 5, 5));
		offer_pair(pack_seg(1, 2, 1, 2, -5, -5, 5, 5));
		// seg2 a point on seg1, and off it
		offer_pair(pack_seg(-4, 8, 4, -8, 2, -4, 2, -4));
		offer_pair(pack_seg(-4, 8, 4, -8, 2, -3, 2, -3));
		// strict crossing, T contact, shared endpoint, clean miss
		offer_pair(pack_seg(-10, 0, 10, 0, 0, -10, 0, 10));
		offer_pair(pack_seg(-10, 0, 10, 0, 0, 0, 0, 10));
		offer_pair(pack_seg(0, 0, 10, 0, 10, 0, 20, 5));
		offer_pair(pack_seg(0, 0, 10, 3, 4, 5, 12, 20));
		// parallel apart
		offer_pair(pack_seg(0, 0, 10, 10, 0, 1, 10, 11));
		// collinear: overlap, single touching point, gap
		offer_pair(pack_seg(0, 0, 10, 10, 20, 20, 5, 5));
		offer_pair(pack_seg(0, 0, 5, 5, 5, 5, 9, 9));
		offer_pair(pack_seg(0, 0, 3, 3, 5, 5, 9, 9));
		// vertical collinear, ordered by y
		offer_pair(pack_seg(3, 0, 3, 10, 3, 10, 3, 2));
		// full-range diagonals crossing at the centre
		offer_pair(pack_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		// identical full-range segment, one reversed
		offer_pair(pack_seg(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768));
		// all-ones and sign-bit corners
		offer_pair(pack_seg(32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767));
		offer_pair(pack_seg(-32768, 32767, 32767, -32768, -1, -1, 0, 0));

		// Strict mode: only proper crossings and stretches count
		write_touch(1'b0);
		random_run(150);

		// Back to touching counted, no idling either side for a stretch
		write_touch(1'b1);
		tx_gaps = 1'b0;
		rx_stalls <= 1'b0;
		random_run(150);

		// Long receiver hold-off while the sender keeps offering
		hold_phase <= 1'b1;
		random_run(30);
		hold_phase <= 1'b0;

		// Sender pause until everything has drained, then idling resumes
		settle();
		tx_gaps = 1'b1;
		rx_stalls <= 1'b1;
		random_run(150);

		write_touch(1'b0);
		random_run(100);
		write_touch(1'b1);
		random_run(70);

		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/spit_pkg.sv
hw/rtl/segment_pair_intersect_test_unit.sv
dv/segment_intersect_checker.sv
dv/testbench.sv
